// ===== hw/rtl/lbpts_pkg.sv =====
// Shared types and constants for the light bar pairing target select block.
package lbpts_pkg;

  localparam int COORD_W  = 13;
  localparam int HEIGHT_W = 12;
  localparam int RATIO_W  = 10;
  localparam int POS_W    = 14;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RATIO_LOW    = 2'd2;
  localparam logic [1:0] REG_RATIO_HIGH   = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0]  x2;
    logic [COORD_W-1:0]  y2;
    logic [HEIGHT_W-1:0] h;
  } bar_t;

  typedef struct packed {
    logic [COORD_W-1:0] frame_width;
    logic [COORD_W-1:0] frame_height;
    logic [RATIO_W-1:0] ratio_low;
    logic [RATIO_W-1:0] ratio_high;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store;      // write incoming bar, or flag overflow
    logic start_i;    // load the outer bar and set j = i + 1
    logic read_j;     // issue store read at j
    logic calc;       // stage 1: differences and squares
    logic mul;        // stage 2: ratio products
    logic judge;      // stage 3: compare and update best
    logic next_i;     // advance i
    logic finish;     // commit result, clear frame
  } cmd_t;

  typedef struct packed {
    logic i_done;     // i reached bar count
    logic i_paired;   // bar i is already paired
    logic j_done;     // j reached bar count
    logic j_paired;   // bar j is already paired
    logic pair_hit;   // last judged pair passed
  } sts_t;

endpackage

// ===== hw/rtl/lbpts_datapath.sv =====
// Bar store, pair test pipeline and best-target tracking.
module lbpts_datapath #(
  parameter int MAX_BARS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lbpts_pkg::cmd_t               cmd,
  output lbpts_pkg::sts_t               sts,
  input  lbpts_pkg::cfg_t               cfg,
  input  lbpts_pkg::bar_t               bar_in,
  output logic                          res_found,
  output logic [lbpts_pkg::POS_W-1:0]   res_x4,
  output logic [lbpts_pkg::POS_W-1:0]   res_y4,
  output logic                          res_dropped
);

  localparam int IDX_W = (MAX_BARS > 1) ? $clog2(MAX_BARS) : 1;
  localparam int CNT_W = $clog2(MAX_BARS + 1);

  lbpts_pkg::bar_t mem [MAX_BARS];
  lbpts_pkg::bar_t rd_data;
  lbpts_pkg::bar_t bar_i;

  logic [MAX_BARS-1:0] paired;
  logic [CNT_W-1:0]    count;
  logic                overflow;
  logic [CNT_W-1:0]    i_idx;
  logic [CNT_W-1:0]    j_idx;
  logic [CNT_W-1:0]    j_cur;

  // Stage registers of the pair test.
  logic [27:0] d2;
  logic [47:0] hsq;
  logic [19:0] lo_sq;
  logic [19:0] hi_sq;
  logic [lbpts_pkg::POS_W-1:0] x4;
  logic [lbpts_pkg::POS_W-1:0] y4;
  logic [28:0] cd;
  logic [47:0] lo_p;
  logic [47:0] hi_p;
  logic        hit;

  logic                found;
  logic [lbpts_pkg::POS_W-1:0] bx;
  logic [lbpts_pkg::POS_W-1:0] by;
  logic [28:0]         bd;

  logic [lbpts_pkg::COORD_W-1:0] dx;
  logic [lbpts_pkg::COORD_W-1:0] dy;
  logic [lbpts_pkg::POS_W:0]     ex;
  logic [lbpts_pkg::POS_W:0]     ey;
  logic [lbpts_pkg::POS_W-1:0]   sx;
  logic [lbpts_pkg::POS_W-1:0]   sy;
  logic [lbpts_pkg::POS_W:0]     fx;
  logic [lbpts_pkg::POS_W:0]     fy;
  logic [22:0]                   hs;

  always_comb begin
    dx = (bar_i.x2 > rd_data.x2) ? bar_i.x2 - rd_data.x2 : rd_data.x2 - bar_i.x2;
    dy = (bar_i.y2 > rd_data.y2) ? bar_i.y2 - rd_data.y2 : rd_data.y2 - bar_i.y2;
    sx = {1'b0, bar_i.x2} + {1'b0, rd_data.x2};
    sy = {1'b0, bar_i.y2} + {1'b0, rd_data.y2};
    fx = {1'b0, cfg.frame_width, 1'b0};
    fy = {1'b0, cfg.frame_height, 1'b0};
    ex = ({1'b0, sx} > fx) ? {1'b0, sx} - fx : fx - {1'b0, sx};
    ey = ({1'b0, sy} > fy) ? {1'b0, sy} - fy : fy - {1'b0, sy};
    hs = {bar_i.h, 11'd0};
  end

  always_ff @(posedge clk) begin
    if (cmd.store && count < CNT_W'(MAX_BARS)) begin
      mem[count[IDX_W-1:0]] <= bar_in;
    end
    if (cmd.start_i) begin
      rd_data <= mem[i_idx[IDX_W-1:0]];
    end else if (cmd.read_j) begin
      rd_data <= mem[j_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      paired           <= '0;
      count            <= '0;
      overflow         <= 1'b0;
      i_idx            <= '0;
      j_idx            <= '0;
      found            <= 1'b0;
      res_found        <= 1'b0;
      res_dropped      <= 1'b0;
      res_x4           <= '0;
      res_y4           <= '0;
      hit              <= 1'b0;
    end else begin
      if (cmd.store) begin
        if (count < CNT_W'(MAX_BARS)) begin
          count <= count + 1'b1;
        end else begin
          overflow <= 1'b1;
        end
        i_idx <= '0;
        found <= 1'b0;
      end
      if (cmd.start_i) begin
        j_idx <= i_idx + 1'b1;
      end
      if (cmd.read_j) begin
        j_cur <= j_idx;
        j_idx <= j_idx + 1'b1;
      end
      if (cmd.next_i) begin
        i_idx <= i_idx + 1'b1;
      end
      if (cmd.judge) begin
        hit <= (hsq > lo_p) && (hsq < hi_p);
        if ((hsq > lo_p) && (hsq < hi_p)) begin
          paired[i_idx[IDX_W-1:0]] <= 1'b1;
          paired[j_cur[IDX_W-1:0]] <= 1'b1;
          if (!found || cd < bd) begin
            found <= 1'b1;
            bx    <= x4;
            by    <= y4;
            bd    <= cd;
          end
        end
      end else if (cmd.start_i || cmd.read_j) begin
        hit <= 1'b0;
      end
      if (cmd.finish) begin
        res_found   <= found;
        res_x4      <= found ? bx : '0;
        res_y4      <= found ? by : '0;
        res_dropped <= overflow;
        paired   <= '0;
        count    <= '0;
        overflow <= 1'b0;
      end
    end
  end

  // Latch bar i once its store read lands.
  logic load_i;
  always_ff @(posedge clk) begin
    if (rst) begin
      load_i <= 1'b0;
    end else begin
      load_i <= cmd.start_i;
    end
    if (load_i) begin
      bar_i <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      d2    <= 28'(dx * dx) + 28'(dy * dy);
      hsq   <= 48'(hs * hs);
      lo_sq <= 20'(cfg.ratio_low * cfg.ratio_low);
      hi_sq <= 20'(cfg.ratio_high * cfg.ratio_high);
      x4    <= sx;
      y4    <= sy;
      cd    <= 29'(ex * ex) + 29'(ey * ey);
    end
    if (cmd.mul) begin
      lo_p <= 48'(lo_sq * d2);
      hi_p <= 48'(hi_sq * d2);
    end
  end

  assign sts.i_done   = (i_idx >= count);
  assign sts.i_paired = paired[i_idx[IDX_W-1:0]];
  assign sts.j_done   = (j_idx >= count);
  assign sts.j_paired = paired[j_idx[IDX_W-1:0]];
  assign sts.pair_hit = hit;

endmodule

// ===== hw/rtl/lbpts_ctrl.sv =====
// Controller sequencing bar loads, the pairing pass and result delivery.
module lbpts_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            in_last,
  output logic            out_valid,
  input  logic            out_stall,
  output lbpts_pkg::cmd_t cmd,
  input  lbpts_pkg::sts_t sts
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_OUTER = 4'd1;
  localparam logic [3:0] S_LATCH = 4'd2;
  localparam logic [3:0] S_INNER = 4'd3;
  localparam logic [3:0] S_CALC  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_JUDGE = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_pend;
  logic       take;

  assign in_stall  = (state != S_LOAD);
  assign take      = in_valid && !in_stall;
  assign out_valid = out_pend;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_LOAD: begin
        if (take) begin
          cmd.store = 1'b1;
          if (in_last) begin
            state_next = S_OUTER;
          end
        end
      end
      S_OUTER: begin
        if (sts.i_done) begin
          state_next = S_DONE;
        end else if (sts.i_paired) begin
          cmd.next_i = 1'b1;
        end else begin
          cmd.start_i = 1'b1;
          state_next  = S_LATCH;
        end
      end
      S_LATCH: begin
        state_next = S_INNER;
      end
      S_INNER: begin
        if (sts.j_done) begin
          cmd.next_i = 1'b1;
          state_next = S_OUTER;
        end else if (sts.j_paired) begin
          cmd.read_j = 1'b1;
        end else begin
          cmd.read_j = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_JUDGE;
      end
      S_JUDGE: begin
        cmd.judge  = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.pair_hit) begin
          cmd.next_i = 1'b1;
          state_next = S_OUTER;
        end else begin
          state_next = S_INNER;
        end
      end
      S_DONE: begin
        if (!out_pend || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      out_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_pend <= 1'b1;
      end else if (!out_stall) begin
        out_pend <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/light_bar_pairing_target_select_core.sv =====
// Top level of the light bar pairing target select block.
// Usage:
//   Feed one light bar per input transaction (bar_x2, bar_y2, bar_height,
//   last_bar) on the in_valid / in_stall channel. Bars load one per cycle
//   while in_stall is low into a MAX_BARS-entry store; bars beyond
//   capacity are dropped and flagged in bars_dropped. The bar with
//   last_bar set starts the pairing pass, during which in_stall stays high.
//   Pairing visits each unpaired bar i and scans later unpaired bars j;
//   each tested pair steps through store read, squares, ratio products,
//   compare and decide; skipped bars bypass the pair test. Pairing time
//   is bound by the single shared pair-test pipeline and the one store
//   read port.
//   One result transaction per frame leaves on out_valid / out_stall; it
//   is held in an output register, and a stalled result holds its value.
//   A new frame loads while the previous result still waits.
//   Synchronous reset restores default configuration and empties the
//   frame; the bar store itself is not cleared and needs no sweep.
//   Configure through the APB port only while the block is idle.
module light_bar_pairing_target_select_core #(
  parameter int MAX_BARS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [12:0] bar_x2,
  input  logic [12:0] bar_y2,
  input  logic [11:0] bar_height,
  input  logic        last_bar,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        target_found,
  output logic [13:0] target_x4,
  output logic [13:0] target_y4,
  output logic        bars_dropped
);

  lbpts_pkg::cfg_t cfg;
  lbpts_pkg::cmd_t cmd;
  lbpts_pkg::sts_t sts;
  lbpts_pkg::bar_t bar_in;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Register file: write on the access phase, read back any time.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= 13'd640;
      cfg.frame_height <= 13'd480;
      cfg.ratio_low    <= 10'd358;
      cfg.ratio_high   <= 10'd696;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        lbpts_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[12:0];
        lbpts_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[12:0];
        lbpts_pkg::REG_RATIO_LOW:    cfg.ratio_low    <= pwdata[9:0];
        lbpts_pkg::REG_RATIO_HIGH:   cfg.ratio_high   <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      lbpts_pkg::REG_FRAME_WIDTH:  prdata = {19'd0, cfg.frame_width};
      lbpts_pkg::REG_FRAME_HEIGHT: prdata = {19'd0, cfg.frame_height};
      lbpts_pkg::REG_RATIO_LOW:    prdata = {22'd0, cfg.ratio_low};
      lbpts_pkg::REG_RATIO_HIGH:   prdata = {22'd0, cfg.ratio_high};
      default:                     prdata = '0;
    endcase
  end

  assign bar_in.x2 = bar_x2;
  assign bar_in.y2 = bar_y2;
  assign bar_in.h  = bar_height;

  lbpts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (last_bar),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  lbpts_datapath #(
    .MAX_BARS (MAX_BARS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg         (cfg),
    .bar_in      (bar_in),
    .res_found   (target_found),
    .res_x4      (target_x4),
    .res_y4      (target_y4),
    .res_dropped (bars_dropped)
  );

endmodule

// ===== sim/light_bar_pairing_target_select_core_checker.sv =====
// Checker for the light bar pairing block: frame predictor and result scoreboard.
module light_bar_pairing_target_select_core_checker #(
  parameter int MAX_BARS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [lbpts_pkg::COORD_W-1:0]  bar_x2,
  input  logic [lbpts_pkg::COORD_W-1:0]  bar_y2,
  input  logic [lbpts_pkg::HEIGHT_W-1:0] bar_height,
  input  logic                           last_bar,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic                           target_found,
  input  logic [lbpts_pkg::POS_W-1:0]    target_x4,
  input  logic [lbpts_pkg::POS_W-1:0]    target_y4,
  input  logic                           bars_dropped,
  output int                             fail_count,
  output int                             pending_targets
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                        found;
    logic [lbpts_pkg::POS_W-1:0] x4;
    logic [lbpts_pkg::POS_W-1:0] y4;
    logic                        dropped;
  } target_t;

  lbpts_pkg::cfg_t cfg;
  lbpts_pkg::bar_t frame_bars[MAX_BARS];
  bit              bar_taken[MAX_BARS];
  int              frame_len;
  bit              frame_overflow;
  target_t         target_q[$];

  assign pending_targets = target_q.size();

  function automatic longint unsigned sq_gap(longint unsigned a, longint unsigned b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic bit bars_match(lbpts_pkg::bar_t a, lbpts_pkg::bar_t b);
    longint unsigned d2, hs, lhs;
    d2  = sq_gap(a.x2, b.x2) + sq_gap(a.y2, b.y2);
    hs  = longint'(a.h) * 2048;
    lhs = hs * hs;
    return lhs > longint'(cfg.ratio_low) * cfg.ratio_low * d2 &&
           lhs < longint'(cfg.ratio_high) * cfg.ratio_high * d2;
  endfunction

  // Greedy pass over the stored frame; nearest armor center wins.
  function automatic target_t select_target();
    target_t         t;
    longint unsigned d, bd;
    logic [14:0]     x4, y4;
    t  = '0;
    bd = 0;
    for (int i = 0; i < frame_len; i++) begin
      if (bar_taken[i]) continue;
      for (int j = i + 1; j < frame_len; j++) begin
        if (bar_taken[j]) continue;
        if (bars_match(frame_bars[i], frame_bars[j])) begin
          x4 = frame_bars[i].x2 + frame_bars[j].x2;
          y4 = frame_bars[i].y2 + frame_bars[j].y2;
          d  = sq_gap(x4, 2 * cfg.frame_width) + sq_gap(y4, 2 * cfg.frame_height);
          if (!t.found || d < bd) begin
            t.found = 1'b1;
            t.x4 = x4[lbpts_pkg::POS_W-1:0];
            t.y4 = y4[lbpts_pkg::POS_W-1:0];
            bd = d;
          end
          bar_taken[i] = 1'b1;
          bar_taken[j] = 1'b1;
          break;
        end
      end
    end
    t.dropped = frame_overflow;
    return t;
  endfunction

  always @(posedge clk) begin
    target_t         got, want;
    lbpts_pkg::bar_t b;
    if (rst) begin
      cfg            <= '{frame_width: 13'd640, frame_height: 13'd480,
                          ratio_low: 10'd358, ratio_high: 10'd696};
      frame_len      = 0;
      frame_overflow = 0;
      fail_count     <= 0;
      foreach (bar_taken[k]) bar_taken[k] = 0;
      target_q.delete();
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          lbpts_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[lbpts_pkg::COORD_W-1:0];
          lbpts_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[lbpts_pkg::COORD_W-1:0];
          lbpts_pkg::REG_RATIO_LOW:    cfg.ratio_low    <= pwdata[lbpts_pkg::RATIO_W-1:0];
          lbpts_pkg::REG_RATIO_HIGH:   cfg.ratio_high   <= pwdata[lbpts_pkg::RATIO_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        b = '{x2: bar_x2, y2: bar_y2, h: bar_height};
        if (frame_len < MAX_BARS) begin
          frame_bars[frame_len] = b;
          frame_len++;
        end else begin
          frame_overflow = 1;
        end
        if (last_bar) begin
          target_q       = {target_q, select_target()};
          frame_len      = 0;
          frame_overflow = 0;
          foreach (bar_taken[k]) bar_taken[k] = 0;
        end
      end
      if (out_valid && !out_stall) begin
        got = '{found: target_found, x4: target_x4, y4: target_y4,
                dropped: bars_dropped};
        if (target_q.size() == 0) begin
          $display("%0t: unexpected target %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = target_q.pop_front();
          if (got !== want) begin
            $display("%0t: target mismatch expected %p actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/light_bar_pairing_target_select_core_test.sv =====
// Testbench top for the light bar pairing block: stimulus, register setup and verdict.
module light_bar_pairing_target_select_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BARS = 32;

  logic        clk = 0;
  logic        rst = 1;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_stall;
  logic [12:0] bar_x2 = '0, bar_y2 = '0;
  logic [11:0] bar_height = '0;
  logic        last_bar = 0;
  logic        out_valid;
  logic        out_stall = 1;
  logic        target_found, bars_dropped;
  logic [13:0] target_x4, target_y4;
  int          fail_count, pending_targets;
  bit          stim_done = 0;

  light_bar_pairing_target_select_core #(.MAX_BARS(MAX_BARS)) dut (.*);

  light_bar_pairing_target_select_core_checker #(.MAX_BARS(MAX_BARS)) scoreboard (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: stall at random; long stretches of no stall too.
  initial begin
    int n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      out_stall <= 1'b0;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 8);
      repeat (n) @(negedge clk);
      n = rand_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic reg_write(logic [1:0] idx, int unsigned value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(int unsigned fw, int unsigned fh, int unsigned lo, int unsigned hi);
    reg_write(lbpts_pkg::REG_FRAME_WIDTH, fw);
    reg_write(lbpts_pkg::REG_FRAME_HEIGHT, fh);
    reg_write(lbpts_pkg::REG_RATIO_LOW, lo);
    reg_write(lbpts_pkg::REG_RATIO_HIGH, hi);
  endtask

  // Present one bar and hold it until accepted; keep valid high when no gap follows.
  task automatic send_bar(logic [12:0] x, logic [12:0] y, logic [11:0] h, logic last);
    int gap;
    in_valid   <= 1'b1;
    bar_x2     <= x;
    bar_y2     <= y;
    bar_height <= h;
    last_bar   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_targets != 0) @(negedge clk);
    // Let the block finish any pairing pass before touching the registers.
    repeat (3000) @(negedge clk);
  endtask

  // A frame of plausible bars: pairs spaced so the ratio test often passes.
  task automatic send_frame(int n);
    int unsigned x, y, h, dx;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_bar(13'($urandom), 13'($urandom), 12'($urandom), k == n - 1);
      end else begin
        h  = $urandom_range(4, 400);
        dx = h * 2 * $urandom_range(2, 6);   // doubled distance 4*h..12*h
        x  = $urandom_range(0, 8191);
        y  = $urandom_range(0, 8191);
        if (k % 2 == 1) x = (x + dx) % 8192;
        send_bar(13'(x), 13'(y), 12'(h), k == n - 1);
      end
    end
  endtask

  initial begin
    int sent;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: extremes, coincident bars, a good pair, single bar.
    send_bar(13'd0, 13'd0, 12'd0, 1'b1);
    send_bar(13'h1FFF, 13'h1FFF, 12'hFFF, 1'b0);
    send_bar(13'h1FFF, 13'h1FFF, 12'hFFF, 1'b1);
    send_bar(13'd600, 13'd480, 12'd50, 1'b0);
    send_bar(13'd800, 13'd480, 12'd50, 1'b0);
    send_bar(13'd0, 13'h1FFF, 12'd100, 1'b0);
    send_bar(13'h1FFF, 13'd0, 12'd1, 1'b1);
    // Store full: overflow and a dropped last bar.
    for (int k = 0; k < MAX_BARS + 2; k++)
      send_bar(13'(k * 100), 13'd500, 12'd60, k == MAX_BARS + 1);
    drain();

    // Swapped and equal bounds, then the frame registers at 1 and 4096.
    set_config(4096, 4096, 1023, 0);
    send_bar(13'd600, 13'd480, 12'd50, 1'b0);
    send_bar(13'd800, 13'd480, 12'd50, 1'b1);
    drain();
    set_config(1, 1, 500, 500);
    send_frame(4);
    drain();
    set_config(1, 4096, 0, 1023);
    send_frame(6);
    drain();

    // Random part across several settings, a pause until fully drained after each.
    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(640, 480, 358, 696);
        1: set_config(4096, 1, 0, 1023);
        2: set_config($urandom_range(1, 4096), $urandom_range(1, 4096),
                      $urandom_range(0, 1023), $urandom_range(0, 1023));
        3: set_config(1, 1, 100, 900);
        4: set_config($urandom_range(1, 4096), $urandom_range(1, 4096), 200, 1000);
        default: set_config(640, 480, 358, 696);
      endcase
      while (sent < (phase + 1) * 232) begin
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(MAX_BARS, MAX_BARS + 3)
                                         : $urandom_range(1, 8);
        send_frame(n);
        sent += n;
      end
      drain();
    end
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (fail_count == 0)
      $display("light_bar_pairing_target_select_core regression: pass");
    else
      $display("light_bar_pairing_target_select_core regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("light_bar_pairing_target_select_core regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/lbpts_pkg.sv
hw/rtl/lbpts_datapath.sv
hw/rtl/lbpts_ctrl.sv
hw/rtl/light_bar_pairing_target_select_core.sv
sim/light_bar_pairing_target_select_core_checker.sv
sim/light_bar_pairing_target_select_core_test.sv
